@@ sv/mp4_cover_box_extractor_assert.svh @@
// Assertion macros for the cover box extractor RTL, included by mcbe_parser.
// Expects signals named clk and rst in the including module.
`ifndef MP4_COVER_BOX_EXTRACTOR_ASSERT_SVH
`define MP4_COVER_BOX_EXTRACTOR_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define MCBE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MCBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/mcbe_pkg.sv @@
// Package for the MP4 cover box extractor: phase and result codes,
// box path table, result struct. No dependencies.
package mcbe_pkg;

  localparam int POSITION_BITS_DEFAULT = 64;
  localparam logic [2:0] PATH_LEN = 3'd6;
  localparam logic [31:0] FOURCC_FTYP = 32'h66747970;

  typedef enum logic [4:0] {
    PH_FTYP    = 5'b00001,
    PH_HDR     = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  function automatic logic [31:0] path_type(input logic [2:0] lvl);
    logic [31:0] t;
    unique case (lvl)
      3'd0:    t = 32'h6d6f6f76; // moov
      3'd1:    t = 32'h75647461; // udta
      3'd2:    t = 32'h6d657461; // meta
      3'd3:    t = 32'h696c7374; // ilst
      3'd4:    t = 32'h636f7672; // covr
      3'd5:    t = 32'h64617461; // data
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // bytes skipped after a matched header (meta version/flags, data type/locale)
  function automatic logic [3:0] path_skip(input logic [2:0] lvl);
    logic [3:0] s;
    unique case (lvl)
      3'd2:    s = 4'd4;
      3'd5:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

@@ sv/mcbe_if.sv @@
// Stream interfaces for the cover box extractor: file bytes in, results out.
// Depends on nothing.
interface mcbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_file;

  modport source (output valid, data_byte, first_byte, end_of_file, input ready);
  modport sink (input valid, data_byte, first_byte, end_of_file, output ready);
endinterface

interface mcbe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic       payload_last;

  modport source (output valid, result_kind, payload_byte, payload_last, input ready);
  modport sink (input valid, result_kind, payload_byte, payload_last, output ready);
endinterface

@@ sv/mcbe_parser.sv @@
// Box walker for the cover box extractor: parse state and per-byte next-state logic.
// Depends on mcbe_pkg and mp4_cover_box_extractor_assert.svh.
`include "mp4_cover_box_extractor_assert.svh"

module mcbe_parser #(
  parameter int POSITION_BITS = mcbe_pkg::POSITION_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              end_of_file,
  output logic              res_valid,
  output mcbe_pkg::result_t res
);
  import mcbe_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};

  phase_t                   phase, phase_next, cur_phase;
  logic [2:0]               level, level_next, cur_level;
  logic [63:0]              header_shift, header_shift_next, cur_shift;
  logic [2:0]               header_count, header_count_next, cur_count;
  logic [POSITION_BITS-1:0] position, position_next, cur_pos;
  logic [POSITION_BITS-1:0] parent_end, parent_end_next, cur_pend;
  logic [31:0]              bytes_to_skip, bytes_to_skip_next, cur_skip;

  logic [31:0]              box_size, box_type, skip_left, tail;
  logic [3:0]               extra;
  logic [POSITION_BITS-1:0] box_end;
  logic                     do_after, bad_size;

  always_comb begin
    cur_phase = first_byte ? PH_FTYP : phase;
    cur_level = first_byte ? 3'd0 : level;
    cur_shift = first_byte ? 64'd0 : header_shift;
    cur_count = first_byte ? 3'd0 : header_count;
    cur_pos   = first_byte ? '0 : position;
    cur_pend  = first_byte ? POS_MAX : parent_end;
    cur_skip  = first_byte ? 32'd0 : bytes_to_skip;

    phase_next         = cur_phase;
    level_next         = cur_level;
    header_shift_next  = cur_shift;
    header_count_next  = cur_count;
    position_next      = cur_pos;
    parent_end_next    = cur_pend;
    bytes_to_skip_next = cur_skip;

    res_valid = 1'b0;
    res       = '{kind: KIND_BYTE, data: 8'd0, last: 1'b0};
    do_after  = 1'b0;

    header_shift_next = {cur_shift[55:0], data_byte};
    box_size  = header_shift_next[63:32];
    box_type  = header_shift_next[31:0];
    bad_size  = (box_size < 32'd8) || box_size[31];
    extra     = path_skip(cur_level);
    box_end   = cur_pos + POSITION_BITS'(box_size);
    skip_left = cur_skip - 32'd1;

    unique case (cur_phase)
      PH_FTYP, PH_HDR: begin
        if (cur_count == 3'd7) begin
          header_count_next = 3'd0;
          if (bad_size) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res.kind   = KIND_FAIL;
          end else if (cur_phase == PH_FTYP) begin
            if (box_type != FOURCC_FTYP) begin
              phase_next = PH_DONE;
              res_valid  = 1'b1;
              res.kind   = KIND_FAIL;
            end else begin
              position_next      = POSITION_BITS'(box_size);
              bytes_to_skip_next = box_size - 32'd8;
              phase_next         = PH_SKIP;
              do_after           = (bytes_to_skip_next == 32'd0);
            end
          end else if (cur_level >= PATH_LEN || box_end > cur_pend) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res.kind   = KIND_FAIL;
          end else if (box_type == path_type(cur_level)) begin
            if (box_size < 32'd8 + 32'(extra)) begin
              phase_next = PH_DONE;
              res_valid  = 1'b1;
              res.kind   = KIND_FAIL;
            end else begin
              parent_end_next    = box_end;
              position_next      = cur_pos + POSITION_BITS'(5'd8 + 5'(extra));
              level_next         = cur_level + 3'd1;
              bytes_to_skip_next = 32'(extra);
              phase_next         = PH_SKIP;
              do_after           = (extra == 4'd0);
            end
          end else begin
            position_next      = box_end;
            bytes_to_skip_next = box_size - 32'd8;
            phase_next         = PH_SKIP;
            do_after           = (bytes_to_skip_next == 32'd0);
          end
        end else begin
          header_count_next = cur_count + 3'd1;
        end
      end
      PH_SKIP: begin
        header_shift_next = cur_shift;
        if (cur_skip != 32'd0) begin
          bytes_to_skip_next = skip_left;
        end
        do_after = (bytes_to_skip_next == 32'd0);
      end
      PH_PAYLOAD: begin
        header_shift_next = cur_shift;
        if (cur_skip != 32'd0) begin
          bytes_to_skip_next = skip_left;
        end
        res_valid = 1'b1;
        res.data  = data_byte;
        if (bytes_to_skip_next == 32'd0) begin
          phase_next = PH_DONE;
          res.last   = 1'b1;
        end
      end
      default: begin
        header_shift_next = cur_shift;
      end
    endcase

    tail = parent_end_next[31:0] - position_next[31:0];
    if (do_after) begin
      if (level_next < PATH_LEN) begin
        phase_next = PH_HDR;
      end else begin
        bytes_to_skip_next = tail;
        if (tail == 32'd0) begin
          phase_next = PH_DONE;
          res_valid  = 1'b1;
          res.kind   = KIND_EMPTY;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end

    if (end_of_file && cur_phase != PH_DONE && phase_next != PH_DONE) begin
      phase_next = PH_DONE;
      res_valid  = 1'b1;
      res        = '{kind: KIND_FAIL, data: 8'd0, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FTYP;
      level         <= 3'd0;
      header_shift  <= 64'd0;
      header_count  <= 3'd0;
      position      <= '0;
      parent_end    <= POS_MAX;
      bytes_to_skip <= 32'd0;
    end else if (step_en) begin
      phase         <= phase_next;
      level         <= level_next;
      header_shift  <= header_shift_next;
      header_count  <= header_count_next;
      position      <= position_next;
      parent_end    <= parent_end_next;
      bytes_to_skip <= bytes_to_skip_next;
    end
  end

  `MCBE_ASSERT_ALWAYS(a_level_range, level <= PATH_LEN, "level past end of path")
  `MCBE_ASSERT_ALWAYS(a_payload_level, phase != PH_PAYLOAD || level == PATH_LEN, "payload before data box")
  `MCBE_ASSERT_ALWAYS(a_skip_nonzero, (phase != PH_SKIP && phase != PH_PAYLOAD) || bytes_to_skip != 32'd0, "skip phase with nothing to skip")
  `MCBE_ASSERT_ALWAYS(a_done_quiet, !(step_en && phase == PH_DONE && !first_byte) || !res_valid, "result after parse finished")
  `MCBE_ASSERT_NEXT(a_done_holds, step_en && res_valid && res.kind != KIND_BYTE, phase == PH_DONE, "terminal result without done")

endmodule

@@ sv/mp4_cover_box_extractor.sv @@
// Top level of the MP4 cover box extractor: input register, box walker, result register.
// Depends on mcbe_pkg, mcbe_if and mcbe_parser.
//
// Takes one file byte per cycle and returns the payload of moov/udta/meta/ilst/covr/data
// one byte per result, the last marked, or one finished-empty or failed result. Every byte
// is handled combinationally by the walker between the input register and the result
// register, so the block sustains one byte per clock and stalls only while a result waits
// on cover_stream.ready; a result passes from the walker into the result register and is
// offered from there. Bytes that give no result simply disappear. A failed result means
// any payload bytes already delivered are to be dropped. After a final result bytes are
// ignored until one arrives with first_byte set, which restarts the parse on that byte.
module mp4_cover_box_extractor #(
  parameter int POSITION_BITS = mcbe_pkg::POSITION_BITS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  mcbe_in_if.sink     file_stream,
  mcbe_out_if.source  cover_stream
);
  import mcbe_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_eof;
  logic       step_en;
  logic       stage_ready;
  logic       res_valid;
  result_t    res;
  logic       out_valid;
  result_t    out_res;

  assign stage_ready       = !out_valid || cover_stream.ready;
  assign step_en           = in_valid && stage_ready;
  assign file_stream.ready = !in_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (file_stream.ready) begin
      in_valid <= file_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (file_stream.ready && file_stream.valid) begin
      in_byte  <= file_stream.data_byte;
      in_first <= file_stream.first_byte;
      in_eof   <= file_stream.end_of_file;
    end
  end

  mcbe_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step_en    (step_en),
    .data_byte  (in_byte),
    .first_byte (in_first),
    .end_of_file(in_eof),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= res_valid;
    end else if (cover_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res <= res;
    end
  end

  assign cover_stream.valid        = out_valid;
  assign cover_stream.result_kind  = out_res.kind;
  assign cover_stream.payload_byte = out_res.data;
  assign cover_stream.payload_last = out_res.last;

endmodule
